### rtl/core/ihex_pkg.sv
// ---------------------------------------------------------------------------
// ihex_pkg
// Shared types, codes and default sizes for the Intel HEX record parser.
// ---------------------------------------------------------------------------
`default_nettype none

package ihex_pkg;

  // default queue depths
  localparam int TOKEN_DEPTH_DEF  = 4;
  localparam int RESULT_DEPTH_DEF = 2;

  // result kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_CHAR = 2'd1;
  localparam logic [1:0] ERR_REC  = 2'd2;
  localparam logic [1:0] ERR_SUM  = 2'd3;

  // record types and the byte counts they require
  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_EXT_LIN   = 8'h04;
  localparam logic [7:0] REC_START_LIN = 8'h05;
  localparam logic [7:0] LEN_EXT_LIN   = 8'h02;
  localparam logic [7:0] LEN_START_LIN = 8'h04;

  localparam logic [7:0] ASCII_COLON = 8'h3A;

  // classified character passed from front to back; neither flag set = bad char
  typedef struct packed {
    logic       colon;
    logic       hex;
    logic [3:0] nib;
  } token_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic [1:0]  error_code;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/intel_hex_record_parser_top.sv
// ---------------------------------------------------------------------------
// intel_hex_record_parser_top
// Intel HEX text parser: one ASCII character per request in, memory writes,
// record acknowledgements and errors out.
// ---------------------------------------------------------------------------
// Path: an accepted character is queued as a token; the parser pops it and
//   writes its result (if any) into the result queue, whose head is shown.
// Throughput: one character per cycle, sustained as long as results are
//   popped; the parser state machine retires one token per cycle.
// Reset (rst, synchronous): empties both queues, parser back to awaiting ':'
//   with zero base and sum; also the only way out of the halted state.
`default_nettype none

module intel_hex_record_parser_top #(
  parameter int TOKEN_DEPTH  = ihex_pkg::TOKEN_DEPTH_DEF,
  parameter int RESULT_DEPTH = ihex_pkg::RESULT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // character request side
  input  wire logic        push,
  input  wire logic [7:0]  char_in,
  output logic             full,
  // result side
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [31:0]      write_address,
  output logic [7:0]       write_data,
  output logic [1:0]       error_code
);

  import ihex_pkg::*;

  token_t                     tok;
  logic                       tok_valid;
  logic                       tok_pop;
  logic                       res_push;
  logic                       res_full;
  result_t                    res;
  logic [$bits(result_t)-1:0] res_rdata;
  result_t                    res_head;

  // Front: whitespace is dropped here, everything else is classified into a
  // token and queued. The queue decouples character intake from parsing.
  ihex_front #(
    .TOKEN_DEPTH (TOKEN_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .char_in   (char_in),
    .full      (full),
    .tok       (tok),
    .tok_valid (tok_valid),
    .tok_pop   (tok_pop)
  );

  // Back: record state machine. It only takes a token when the result queue
  // has a free slot, so a produced result is never dropped.
  ihex_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok),
    .tok_valid (tok_valid),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue: head entry is shown on the result ports while not empty.
  ihex_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_head      = result_t'(res_rdata);
  assign kind          = res_head.kind;
  assign write_address = res_head.write_address;
  assign write_data    = res_head.write_data;
  assign error_code    = res_head.error_code;

  // parser never produces a result into a full result queue
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // error results carry a code, all others carry none
  a_code_matches_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code inconsistent with kind");

  // only write results carry an address or data byte
  a_payload_only_on_write: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_WRITE) |-> (write_address == '0 && write_data == '0))
    else $error("non-write result with payload");

endmodule

`default_nettype wire

### rtl/core/ihex_queue.sv
// ---------------------------------------------------------------------------
// ihex_queue
// Small synchronous FIFO with full/empty flags and show-ahead read.
// ---------------------------------------------------------------------------
`default_nettype none

module ihex_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/ihex_front.sv
// ---------------------------------------------------------------------------
// ihex_front
// Character classifier: drops whitespace, decodes hex digits and colons,
// and queues one token per remaining character.
// ---------------------------------------------------------------------------
`default_nettype none

module ihex_front #(
  parameter int TOKEN_DEPTH = ihex_pkg::TOKEN_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire logic [7:0]      char_in,
  output logic                 full,
  output ihex_pkg::token_t     tok,
  output logic                 tok_valid,
  input  wire logic            tok_pop
);

  import ihex_pkg::*;

  logic                      blank;
  token_t                    cls;
  logic                      q_empty;
  logic [$bits(token_t)-1:0] q_rdata;

  // space, TAB, LF, VT, FF, CR
  assign blank = (char_in == 8'h20) || (char_in >= 8'h09 && char_in <= 8'h0D);

  always_comb begin
    cls       = '0;
    cls.colon = (char_in == ASCII_COLON);
    priority if (char_in >= 8'h30 && char_in <= 8'h39) begin
      cls.hex = 1'b1;
      cls.nib = char_in[3:0];
    end else if ((char_in >= 8'h41 && char_in <= 8'h46) ||
                 (char_in >= 8'h61 && char_in <= 8'h66)) begin
      cls.hex = 1'b1;
      cls.nib = char_in[3:0] + 4'd9;
    end else begin
      cls.hex = 1'b0;
    end
  end

  ihex_queue #(
    .WIDTH ($bits(token_t)),
    .DEPTH (TOKEN_DEPTH)
  ) u_tok_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !blank),
    .wdata (cls),
    .full  (full),
    .pop   (tok_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign tok       = token_t'(q_rdata);
  assign tok_valid = !q_empty;

endmodule

`default_nettype wire

### rtl/core/ihex_back.sv
// ---------------------------------------------------------------------------
// ihex_back
// Record state machine: assembles fields, keeps the byte sum and the upper
// linear base, and produces write, accept, end and error results.
// ---------------------------------------------------------------------------
`default_nettype none

module ihex_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ihex_pkg::token_t  tok,
  input  wire logic              tok_valid,
  output logic                   tok_pop,
  input  wire logic              res_full,
  output logic                   res_push,
  output ihex_pkg::result_t      res
);

  import ihex_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_COUNT = 7'b0000010,
    ST_ADDR  = 7'b0000100,
    ST_TYPE  = 7'b0001000,
    ST_DATA  = 7'b0010000,
    ST_CHECK = 7'b0100000,
    ST_HALT  = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [15:0] field_value, field_value_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [16:0] record_offset, record_offset_next;
  logic [7:0]  record_kind, record_kind_next;
  logic [15:0] upper_base, upper_base_next;
  logic [7:0]  running_sum, running_sum_next;

  logic [15:0] fv;
  logic [2:0]  dc;
  logic [7:0]  sum_n;
  logic [7:0]  bl_dec;
  logic [31:0] addr;

  // back side only moves when a result slot is free
  assign tok_pop = tok_valid && !res_full;

  assign fv     = {field_value[11:0], tok.nib};
  assign dc     = digit_count + 3'd1;
  assign sum_n  = running_sum + fv[7:0];
  assign bl_dec = bytes_left - 8'd1;
  assign addr   = {upper_base, 16'h0000} + {15'h0000, record_offset};

  always_comb begin
    state_next         = state;
    digit_count_next   = digit_count;
    field_value_next   = field_value;
    bytes_left_next    = bytes_left;
    record_offset_next = record_offset;
    record_kind_next   = record_kind;
    upper_base_next    = upper_base;
    running_sum_next   = running_sum;
    res_push           = 1'b0;
    res                = '0;

    if (tok_pop) begin
      priority if (state == ST_HALT) begin
        state_next = ST_HALT;
      end else if (state == ST_IDLE) begin
        digit_count_next = '0;
        field_value_next = '0;
        if (tok.colon) begin
          state_next       = ST_COUNT;
          running_sum_next = '0;
        end else begin
          state_next     = ST_HALT;
          res_push       = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_CHAR;
        end
      end else if (!tok.hex) begin
        state_next       = ST_HALT;
        digit_count_next = '0;
        field_value_next = '0;
        res_push         = 1'b1;
        res.kind         = KIND_ERROR;
        res.error_code   = ERR_CHAR;
      end else begin
        field_value_next = fv;
        digit_count_next = dc;
        if (!dc[0]) begin
          running_sum_next = sum_n;
          unique case (state)
            ST_COUNT: begin
              bytes_left_next  = fv[7:0];
              state_next       = ST_ADDR;
              digit_count_next = '0;
              field_value_next = '0;
            end
            ST_ADDR: begin
              if (dc == 3'd4) begin
                record_offset_next = {1'b0, fv};
                state_next         = ST_TYPE;
                digit_count_next   = '0;
                field_value_next   = '0;
              end
            end
            ST_TYPE: begin
              record_kind_next = fv[7:0];
              digit_count_next = '0;
              field_value_next = '0;
              priority if (fv[7:0] == REC_DATA) begin
                state_next = (bytes_left != 8'h00) ? ST_DATA : ST_CHECK;
              end else if (fv[7:0] == REC_EOF && bytes_left == 8'h00 &&
                           record_offset == '0) begin
                state_next = ST_CHECK;
              end else if (fv[7:0] == REC_EXT_LIN && bytes_left == LEN_EXT_LIN &&
                           record_offset == '0) begin
                state_next = ST_DATA;
              end else if (fv[7:0] == REC_START_LIN && bytes_left == LEN_START_LIN &&
                           record_offset == '0) begin
                state_next = ST_DATA;
              end else begin
                // unknown type, or a count/address the type does not allow
                state_next     = ST_HALT;
                res_push       = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_REC;
              end
            end
            ST_DATA: begin
              digit_count_next = '0;
              bytes_left_next  = bl_dec;
              if (record_kind == REC_DATA) begin
                res_push           = 1'b1;
                res.kind           = KIND_WRITE;
                res.write_address  = addr;
                res.write_data     = fv[7:0];
                record_offset_next = record_offset + 17'd1;
              end
              if (bl_dec == 8'h00) begin
                // base is the last two data bytes, taken before the checksum
                if (record_kind == REC_EXT_LIN) begin
                  upper_base_next = fv;
                end
                state_next       = ST_CHECK;
                field_value_next = '0;
              end
            end
            ST_CHECK: begin
              digit_count_next = '0;
              field_value_next = '0;
              res_push         = 1'b1;
              if (sum_n != 8'h00) begin
                state_next     = ST_HALT;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_SUM;
              end else begin
                state_next = ST_IDLE;
                res.kind   = (record_kind == REC_EOF) ? KIND_END : KIND_ACCEPT;
              end
            end
            default: begin
              state_next       = ST_IDLE;
              digit_count_next = '0;
              field_value_next = '0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      digit_count   <= '0;
      field_value   <= '0;
      bytes_left    <= '0;
      record_offset <= '0;
      record_kind   <= '0;
      upper_base    <= '0;
      running_sum   <= '0;
    end else begin
      state         <= state_next;
      digit_count   <= digit_count_next;
      field_value   <= field_value_next;
      bytes_left    <= bytes_left_next;
      record_offset <= record_offset_next;
      record_kind   <= record_kind_next;
      upper_base    <= upper_base_next;
      running_sum   <= running_sum_next;
    end
  end

endmodule

`default_nettype wire
